FILE: rtl/core/all_pairs_shortest_path_macros.svh
// Assertion macros shared by the checker of the shortest path engine
`ifndef ALL_PAIRS_SHORTEST_PATH_MACROS_SVH
`define ALL_PAIRS_SHORTEST_PATH_MACROS_SVH

// Check a consequence in the same cycle as its cause, idle during reset
`define APSP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its cause, idle during reset
`define APSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/apsp_pkg.sv
// Types and constants shared by the shortest path engine modules
`timescale 1ns / 1ps
`default_nettype none

package apsp_pkg;

    localparam int DIST_W         = 32;
    localparam int OP_W           = 2;
    localparam int NODE_W         = 5;
    localparam int WEIGHT_W       = 16;
    localparam int NODE_COUNT_W   = 6;
    localparam int NODE_COUNT_RST = 32;
    localparam int WEIGHT_BITS    = 16;

    localparam logic [DIST_W-1:0]   UNREACHABLE = {DIST_W{1'b1}};
    localparam logic [WEIGHT_W-1:0] WEIGHT_MASK = (WEIGHT_BITS >= WEIGHT_W) ?
                                                  {WEIGHT_W{1'b1}} :
                                                  WEIGHT_W'((1 << WEIGHT_BITS) - 1);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_EDGE  = 2'd1,
        OP_RELAX = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_EDGE_RD,
        ST_EDGE_AB,
        ST_EDGE_BA,
        ST_QRY_RD,
        ST_FW_IK,
        ST_FW_RD,
        ST_FW_WR,
        ST_RESULT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic sweep;
        logic edge_wr_ab;
        logic edge_wr_ba;
        logic fw_ik;
        logic fw_rd;
        logic fw_wr;
        logic result;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_bad;
        logic sweep_last;
        logic j_last;
        logic fw_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

FILE: rtl/core/all_pairs_shortest_path.sv
// Top level of the all-pairs shortest path engine
//
// Input channel (i_in_valid / o_in_stall) carries one item per beat: clear,
// add undirected edge, run relaxation or query one distance. Output channel
// (o_out_valid / i_out_stall) returns exactly one result beat per item.
// i_cfg_we writes the node count; write it only while the block is idle.
// One item is worked at a time, each write to the distance matrix going through
// its single write port. The relaxation walks k, i, j with one read of d[i][k]
// per row and, per entry, a read of both operands, then a compare and write back.
// After reset the matrix is swept to its initial value, one entry a cycle, with
// o_in_stall high. A stalled result sits in the output register while the next
// item is already accepted; that item then waits for the register to empty
// before its own result is loaded.
`timescale 1ns / 1ps
`default_nettype none

module all_pairs_shortest_path
    import apsp_pkg::*;
#(
    parameter int MAX_NODES = 32
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire  [NODE_COUNT_W-1:0] i_cfg_wdata,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  wire  [OP_W-1:0]         i_operation,
    input  wire  [NODE_W-1:0]       i_node_a,
    input  wire  [NODE_W-1:0]       i_node_b,
    input  wire  [WEIGHT_W-1:0]     i_edge_weight,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output logic [DIST_W-1:0]       o_distance,
    output logic                    o_reachable,
    output logic                    o_status
);

    t_cmd cmd;
    t_sts sts;

    // Sequence the work of each item
    apsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall)
    );

    // Matrix, counters and result register
    apsp_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_operation   (i_operation),
        .i_node_a      (i_node_a),
        .i_node_b      (i_node_b),
        .i_edge_weight (i_edge_weight),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_distance    (o_distance),
        .o_reachable   (o_reachable),
        .o_status      (o_status)
    );

endmodule

`default_nettype wire

FILE: rtl/core/apsp_ctrl.sv
// Controller state machine of the shortest path engine
`timescale 1ns / 1ps
`default_nettype none

module apsp_ctrl
    import apsp_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  wire  [OP_W-1:0]  i_operation,
    input  t_sts             i_sts,
    output t_cmd             o_cmd,
    output logic             o_in_stall
);

    t_state r_state;
    t_state n_state;

    // State register, sweep the memory after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (i_sts.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.in_bad) begin
                        n_state = ST_RESULT;
                    end else begin
                        case (t_op'(i_operation))
                            OP_CLEAR: n_state = ST_CLEAR;
                            OP_EDGE:  n_state = ST_EDGE_RD;
                            OP_RELAX: n_state = ST_FW_IK;
                            OP_QUERY: n_state = ST_QRY_RD;
                            default:  n_state = ST_RESULT;
                        endcase
                    end
                end
            end
            ST_CLEAR: begin
                if (i_sts.sweep_last) begin
                    n_state = ST_RESULT;
                end
            end
            ST_EDGE_RD: n_state = ST_EDGE_AB;
            ST_EDGE_AB: n_state = ST_EDGE_BA;
            ST_EDGE_BA: n_state = ST_RESULT;
            ST_QRY_RD:  n_state = ST_RESULT;
            ST_FW_IK:   n_state = ST_FW_RD;
            ST_FW_RD:   n_state = ST_FW_WR;
            ST_FW_WR: begin
                if (i_sts.fw_done) begin
                    n_state = ST_RESULT;
                end else if (i_sts.j_last) begin
                    n_state = ST_FW_IK;
                end else begin
                    n_state = ST_FW_RD;
                end
            end
            ST_RESULT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    // Commands and input stall
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_INIT: o_cmd.sweep = 1'b1;
            ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            ST_CLEAR:   o_cmd.sweep      = 1'b1;
            ST_EDGE_RD: o_cmd            = '0;
            ST_EDGE_AB: o_cmd.edge_wr_ab = 1'b1;
            ST_EDGE_BA: o_cmd.edge_wr_ba = 1'b1;
            ST_QRY_RD:  o_cmd            = '0;
            ST_FW_IK:   o_cmd.fw_ik      = 1'b1;
            ST_FW_RD:   o_cmd.fw_rd      = 1'b1;
            ST_FW_WR:   o_cmd.fw_wr      = 1'b1;
            ST_RESULT:  o_cmd.result     = i_sts.out_free;
            default:    o_cmd            = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/apsp_dp.sv
// Datapath of the shortest path engine: matrix memory, counters, relax unit
`timescale 1ns / 1ps
`default_nettype none

module apsp_dp
    import apsp_pkg::*;
#(
    parameter int MAX_NODES = 32
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire  [NODE_COUNT_W-1:0] i_cfg_wdata,
    input  wire  [OP_W-1:0]         i_operation,
    input  wire  [NODE_W-1:0]       i_node_a,
    input  wire  [NODE_W-1:0]       i_node_b,
    input  wire  [WEIGHT_W-1:0]     i_edge_weight,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  wire                     i_out_stall,
    output logic                    o_out_valid,
    output logic [DIST_W-1:0]       o_distance,
    output logic                    o_reachable,
    output logic                    o_status
);

    localparam int IDX_W  = $clog2(MAX_NODES);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int CMP_W  = (CNT_W > NODE_COUNT_W) ? CNT_W : NODE_COUNT_W;

    logic [NODE_COUNT_W-1:0] r_node_count;
    t_op                     r_op;
    logic                    r_bad;
    logic [IDX_W-1:0]        r_a;
    logic [IDX_W-1:0]        r_b;
    logic [DIST_W-1:0]       r_w;
    logic [ADDR_W-1:0]       r_sweep;
    logic [IDX_W-1:0]        r_k;
    logic [IDX_W-1:0]        r_i;
    logic [IDX_W-1:0]        r_j;
    logic [DIST_W-1:0]       r_ik;
    logic [DIST_W-1:0]       r_rd_a;
    logic [DIST_W-1:0]       r_rd_b;
    logic [DIST_W-1:0]       r_mem [DEPTH];

    logic [CMP_W-1:0]        nc_ext;
    logic [CMP_W-1:0]        cnt_eff;
    logic [CMP_W-1:0]        cnt_last;
    logic                    in_bad;
    logic                    i_last;
    logic                    j_last;
    logic                    k_last;
    logic [ADDR_W-1:0]       raddr_a;
    logic [ADDR_W-1:0]       raddr_b;
    logic                    we;
    logic [ADDR_W-1:0]       waddr;
    logic [DIST_W-1:0]       wdata;
    logic [DIST_W:0]         sum;
    logic [DIST_W-1:0]       cand;
    logic                    relax_upd;
    logic                    is_query;
    logic                    out_free;

    // Clamp the node count to the range 1 .. MAX_NODES
    always_comb begin
        nc_ext = CMP_W'(r_node_count);
        if (nc_ext == '0) begin
            cnt_eff = CMP_W'(1);
        end else if (nc_ext > CMP_W'(MAX_NODES)) begin
            cnt_eff = CMP_W'(MAX_NODES);
        end else begin
            cnt_eff = nc_ext;
        end
        cnt_last = cnt_eff - CMP_W'(1);
    end

    // Reject edges and queries that name a node outside the graph
    assign in_bad = ((t_op'(i_operation) == OP_EDGE) || (t_op'(i_operation) == OP_QUERY)) &&
                    ((CMP_W'(i_node_a) >= cnt_eff) || (CMP_W'(i_node_b) >= cnt_eff));

    assign i_last = (CMP_W'(r_i) == cnt_last);
    assign j_last = (CMP_W'(r_j) == cnt_last);
    assign k_last = (CMP_W'(r_k) == cnt_last);

    assign out_free = !o_out_valid || !i_out_stall;

    always_comb begin
        o_sts            = '0;
        o_sts.in_bad     = in_bad;
        o_sts.sweep_last = &r_sweep;
        o_sts.j_last     = j_last;
        o_sts.fw_done    = i_last && j_last && k_last;
        o_sts.out_free   = out_free;
    end

    // Node count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_W'(NODE_COUNT_RST);
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_wdata;
        end
    end

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= t_op'(i_operation);
            r_bad <= in_bad;
            r_a   <= IDX_W'(i_node_a);
            r_b   <= IDX_W'(i_node_b);
            r_w   <= DIST_W'(i_edge_weight & WEIGHT_MASK);
        end
    end

    // Sweep counter and relaxation loop counters: cleared on capture, then advanced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
            r_k     <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else if (i_cmd.capture) begin
            r_sweep <= '0;
            r_k     <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            if (i_cmd.sweep) begin
                r_sweep <= r_sweep + ADDR_W'(1);
            end
            if (i_cmd.fw_wr) begin
                if (j_last) begin
                    r_j <= '0;
                    if (i_last) begin
                        r_i <= '0;
                        r_k <= r_k + IDX_W'(1);
                    end else begin
                        r_i <= r_i + IDX_W'(1);
                    end
                end else begin
                    r_j <= r_j + IDX_W'(1);
                end
            end
        end
    end

    // Hold d[i][k] for the whole row, read just before the first column
    always_ff @(posedge i_clk) begin
        if (i_cmd.fw_rd && (r_j == '0)) begin
            r_ik <= r_rd_a;
        end
    end

    // Read addresses: item pair by default, relaxation operands when walking
    always_comb begin
        raddr_a = {r_a, r_b};
        raddr_b = {r_b, r_a};
        if (i_cmd.fw_ik) begin
            raddr_a = {r_i, r_k};
        end else if (i_cmd.fw_rd) begin
            raddr_a = {r_i, r_j};
            raddr_b = {r_k, r_j};
        end
    end

    // Relax d[i][j] through k, saturating at the unreachable code
    always_comb begin
        sum       = {1'b0, r_ik} + {1'b0, r_rd_b};
        cand      = (sum >= {1'b0, UNREACHABLE}) ? UNREACHABLE : sum[DIST_W-1:0];
        relax_upd = (r_ik != UNREACHABLE) && (r_rd_b != UNREACHABLE) && (cand < r_rd_a);
    end

    // Write port selection
    always_comb begin
        we    = 1'b0;
        waddr = {r_a, r_b};
        wdata = r_w;
        if (i_cmd.sweep) begin
            we    = 1'b1;
            waddr = r_sweep;
            wdata = (r_sweep[ADDR_W-1:IDX_W] == r_sweep[IDX_W-1:0]) ? '0 : UNREACHABLE;
        end else if (i_cmd.edge_wr_ab) begin
            we    = r_w < r_rd_a;
            waddr = {r_a, r_b};
        end else if (i_cmd.edge_wr_ba) begin
            we    = r_w < r_rd_b;
            waddr = {r_b, r_a};
        end else if (i_cmd.fw_wr) begin
            we    = relax_upd;
            waddr = {r_i, r_j};
            wdata = cand;
        end
    end

    // Distance matrix memory, one write and two registered reads
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd_a <= r_mem[raddr_a];
        r_rd_b <= r_mem[raddr_b];
    end

    assign is_query = (r_op == OP_QUERY) && !r_bad;

    // Output register: load on result, drop once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.result) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result) begin
            o_distance  <= is_query ? r_rd_a : '0;
            o_reachable <= is_query && (r_rd_a != UNREACHABLE);
            o_status    <= r_bad;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/apsp_checker.sv
// Port checker of the shortest path engine and its bind to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "all_pairs_shortest_path_macros.svh"

module apsp_checker
    import apsp_pkg::*;
(
    input wire                    i_clk,
    input wire                    i_rst_n,
    input wire                    i_in_valid,
    input wire                    o_in_stall,
    input wire                    o_out_valid,
    input wire                    i_out_stall,
    input wire [DIST_W-1:0]       o_distance,
    input wire                    o_reachable,
    input wire                    o_status
);

    logic              in_beat;
    logic              out_held;
    logic              out_reach;
    logic              out_reject;
    logic              dist_max;
    logic              dist_zero;
    logic [DIST_W+1:0] out_beat;

    // Condense the port activity
    assign in_beat    = i_in_valid && !o_in_stall;
    assign out_held   = o_out_valid && i_out_stall;
    assign out_reach  = o_out_valid && o_reachable;
    assign out_reject = o_out_valid && o_status;
    assign dist_max   = (o_distance == UNREACHABLE);
    assign dist_zero  = (o_distance == '0);
    assign out_beat   = {o_distance, o_reachable, o_status};

    // A stalled result beat holds
    `APSP_ASSERT_NEXT(a_out_hold, out_held, o_out_valid && $stable(out_beat), "held beat moved")

    // One item at a time: an accepted beat closes the input
    `APSP_ASSERT_NEXT(a_one_item, in_beat, o_in_stall, "input open after a beat")

    // A reachable answer carries a real distance and an ok status
    `APSP_ASSERT_SAME(a_reach_dist, out_reach, !o_status && !dist_max, "reachable beat invalid")

    // A rejected item reports nothing but its status
    `APSP_ASSERT_SAME(a_bad_empty, out_reject, !o_reachable && dist_zero, "rejected beat filled")

endmodule

bind all_pairs_shortest_path apsp_checker u_apsp_checker (.*);

`default_nettype wire
